### rtl/pose_dead_reckoning_predictor_defines.svh
// assertion macros for the pose dead reckoning predictor
// used by files that carry concurrent checks, needs clk_i and rst_ni in scope
`ifndef POSE_DEAD_RECKONING_PREDICTOR_DEFINES_SVH
`define POSE_DEAD_RECKONING_PREDICTOR_DEFINES_SVH

// same-cycle implication
`define PDR_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("pdr check failed");

// next-cycle implication
`define PDR_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("pdr check failed");

`endif

### rtl/pdr_pkg.sv
// shared types, constants and helpers of the pose dead reckoning predictor
// no dependencies
package pdr_pkg;

  localparam int CORDIC_STEPS = 24;
  localparam int ITER_CNT_W   = 6;
  localparam int CW           = 34;  // trig datapath width, q2.30 plus headroom
  localparam int TW           = 36;  // rotated translation width
  localparam int PW           = TW + CW;

  localparam logic signed [CW-1:0] TWO_PI_Q28  = 34'sd1686629713;
  localparam logic signed [CW-1:0] PI_Q28      = 34'sd843314857;
  localparam logic signed [CW-1:0] HALF_PI_Q30 = 34'sd1686629713;
  localparam logic signed [CW-1:0] PI_Q30      = 34'sd3373259426;
  localparam logic signed [CW-1:0] GAIN_Q30    = 34'sd652032874;

  typedef struct packed {
    logic               action;
    logic signed [31:0] vec_x;
    logic signed [31:0] vec_y;
    logic signed [31:0] vec_z;
    logic signed [31:0] ang_x;
    logic signed [31:0] ang_y;
    logic signed [31:0] ang_z;
    logic signed [31:0] step_time;
  } pdr_in_t;

  typedef struct packed {
    logic signed [31:0] next_x;
    logic signed [31:0] next_y;
    logic signed [31:0] next_z;
    logic signed [31:0] next_roll;
    logic signed [31:0] next_pitch;
    logic signed [31:0] next_yaw;
  } pdr_out_t;

  localparam logic ACT_LOAD    = 1'b0;
  localparam logic ACT_PREDICT = 1'b1;

  // floor-truncated q2.30 arctangent of 2^-i
  function automatic logic signed [CW-1:0] atan_q30(input logic [4:0] i);
    logic signed [CW-1:0] r;
    case (i)
      5'd0: r = 34'sd843314856;
      5'd1: r = 34'sd497837829;
      5'd2: r = 34'sd263043836;
      5'd3: r = 34'sd133525158;
      5'd4: r = 34'sd67021686;
      5'd5: r = 34'sd33543515;
      5'd6: r = 34'sd16775850;
      5'd7: r = 34'sd8388437;
      5'd8: r = 34'sd4194282;
      5'd9: r = 34'sd2097149;
      default: begin
        if (i == 5'd31) r = '0;
        else r = (34'sd1 <<< (5'd30 - i)) - 34'sd1;
      end
    endcase
    return r;
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [71:0] v);
    logic signed [31:0] r;
    if (v > 72'sd2147483647) r = 32'sh7fffffff;
    else if (v < -72'sd2147483648) r = 32'sh80000000;
    else r = v[31:0];
    return r;
  endfunction

endpackage

### rtl/pdr_if.sv
// valid/ready channel interfaces for pose items and predicted poses
// depends on pdr_pkg
interface pdr_in_if import pdr_pkg::*; ();
  logic    valid;
  logic    ready;
  pdr_in_t payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

interface pdr_out_if import pdr_pkg::*; ();
  logic     valid;
  logic     ready;
  pdr_out_t payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

### rtl/pdr_cordic.sv
// iterative rotation-mode cordic, one micro-rotation per cycle
// depends on pdr_pkg
module pdr_cordic import pdr_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  input  logic signed [31:0]   angle_i,
  output logic                 done_o,
  output logic signed [CW-1:0] sin_o,
  output logic signed [CW-1:0] cos_o
);

  typedef enum logic [3:0] {
    C_IDLE = 4'b0001,
    C_FOLD = 4'b0010,
    C_ITER = 4'b0100,
    C_DONE = 4'b1000
  } cstate_e;

  cstate_e               state_q, state_d;
  logic [ITER_CNT_W-1:0] it_q, it_d;
  logic signed [CW-1:0]  x_q, x_d, y_q, y_d, z_q, z_d;
  logic                  neg_q, neg_d;
  logic signed [CW-1:0]  a_ext, z4, dx, dy;

  assign a_ext = {{(CW-32){angle_i[31]}}, angle_i};
  assign z4    = z_q <<< 2;
  assign dx    = y_q >>> it_q[4:0];
  assign dy    = x_q >>> it_q[4:0];

  always_comb begin
    state_d = state_q;
    it_d    = it_q;
    x_d     = x_q;
    y_d     = y_q;
    z_d     = z_q;
    neg_d   = neg_q;
    case (state_q)
      C_IDLE: begin
        if (start_i) begin
          // first reduction into [-pi, pi), kept in q4.28
          if (a_ext >= PI_Q28) z_d = a_ext - TWO_PI_Q28;
          else if (a_ext < -PI_Q28) z_d = a_ext + TWO_PI_Q28;
          else z_d = a_ext;
          state_d = C_FOLD;
        end
      end
      C_FOLD: begin
        x_d   = GAIN_Q30;
        y_d   = '0;
        it_d  = '0;
        neg_d = 1'b0;
        if (z4 > HALF_PI_Q30) begin
          z_d   = z4 - PI_Q30;
          neg_d = 1'b1;
        end else if (z4 < -HALF_PI_Q30) begin
          z_d   = z4 + PI_Q30;
          neg_d = 1'b1;
        end else begin
          z_d = z4;
        end
        state_d = C_ITER;
      end
      C_ITER: begin
        if (!z_q[CW-1]) begin
          x_d = x_q - dx;
          y_d = y_q + dy;
          z_d = z_q - atan_q30(it_q[4:0]);
        end else begin
          x_d = x_q + dx;
          y_d = y_q - dy;
          z_d = z_q + atan_q30(it_q[4:0]);
        end
        it_d = it_q + ITER_CNT_W'(1);
        if (it_q == ITER_CNT_W'(CORDIC_STEPS - 1)) state_d = C_DONE;
      end
      C_DONE: state_d = C_IDLE;
      default: state_d = C_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= C_IDLE;
      it_q    <= '0;
    end else begin
      state_q <= state_d;
      it_q    <= it_d;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q   <= x_d;
    y_q   <= y_d;
    z_q   <= z_d;
    neg_q <= neg_d;
  end

  assign done_o = (state_q == C_DONE);
  assign cos_o  = neg_q ? -x_q : x_q;
  assign sin_o  = neg_q ? -y_q : y_q;

endmodule

### rtl/pose_dead_reckoning_predictor.sv
// constant-velocity pose predictor top level: sequencer, shared multiplier, pose store
// depends on pdr_pkg, pdr_if, pdr_cordic and the assertion macro header
`include "pose_dead_reckoning_predictor_defines.svh"

// Holds a pose (position in q16.16 metres, roll/pitch/yaw in q4.28 radians).
// A load transaction (action 0) replaces the pose and yields no output
// transaction. A predict transaction (action 1) advances each angle by
// rate*dt and adds v*dt, rotated by Rz(yaw)*Ry(pitch)*Rx(roll) of the new angles,
// to the position; all outputs saturate and the stored pose is left as is. A
// negative dt returns the stored pose. The input is not ready while a predict
// is in flight. A predict first forms its products on the single multiplier,
// then per axis starts the cordic, waits for its fold, micro-rotations and
// done, and runs the rotation steps; last it loads the output register. Most
// of a predict's time is spent in the iterative cordic. The result sits in
// an output register, so the next item can be taken while it waits; a
// negative dt goes from acceptance straight to loading the output register.
module pose_dead_reckoning_predictor import pdr_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  pdr_in_if.sink    in_i,
  pdr_out_if.source out_o
);

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_MUL  = 6'b000010,
    S_TRIG = 6'b000100,
    S_WAIT = 6'b001000,
    S_ROT  = 6'b010000,
    S_FIN  = 6'b100000
  } state_e;

  state_e state_q, state_d;
  logic [2:0] cnt_q, cnt_d;
  logic [1:0] axis_q, axis_d;

  // stored pose
  logic signed [31:0] pose_pos_q [3];
  logic signed [31:0] pose_ang_q [3];

  // per-transaction working set
  logic signed [31:0] vin_q [6];   // rates then velocities
  logic signed [31:0] dt_q;
  logic signed [31:0] ang_q [3];
  logic signed [TW-1:0] t_q [3];
  logic signed [CW-1:0] s_q, c_q;
  logic signed [PW-1:0] prod_q;
  logic signed [PW:0]   acc_q;

  logic     out_valid_q;
  pdr_out_t out_q;

  logic accept;
  logic cordic_start, cordic_done;
  logic signed [CW-1:0] cordic_sin, cordic_cos;

  // shared multiplier
  logic signed [TW-1:0] mul_a;
  logic signed [CW-1:0] mul_b;
  logic signed [PW-1:0] mul_p;

  // rotation plane of the current axis
  logic [1:0] ri, rj;
  logic signed [CW-1:0] sn;
  logic signed [PW:0]   mix_sum;
  logic signed [TW-1:0] mix_res;
  logic signed [PW-1:0] rnd16;

  assign accept       = in_i.valid && in_i.ready;
  assign in_i.ready   = (state_q == S_IDLE);
  assign cordic_start = (state_q == S_TRIG);

  pdr_cordic u_cordic (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cordic_start),
    .angle_i (ang_q[axis_q]),
    .done_o  (cordic_done),
    .sin_o   (cordic_sin),
    .cos_o   (cordic_cos)
  );

  always_comb begin
    ri = 2'd0;
    rj = 2'd1;
    sn = s_q;
    case (axis_q)
      2'd0: begin
        ri = 2'd1;
        rj = 2'd2;
      end
      2'd1: begin
        ri = 2'd0;
        rj = 2'd2;
        sn = -s_q;  // pitch turns the other way in its plane
      end
      default: begin
        ri = 2'd0;
        rj = 2'd1;
      end
    endcase
  end

  // operand selection for the shared multiplier
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    if (state_q == S_MUL) begin
      mul_b = {{(CW-32){dt_q[31]}}, dt_q};
      case (cnt_q)
        3'd0: mul_a = {{(TW-32){vin_q[0][31]}}, vin_q[0]};
        3'd1: mul_a = {{(TW-32){vin_q[1][31]}}, vin_q[1]};
        3'd2: mul_a = {{(TW-32){vin_q[2][31]}}, vin_q[2]};
        3'd3: mul_a = {{(TW-32){vin_q[3][31]}}, vin_q[3]};
        3'd4: mul_a = {{(TW-32){vin_q[4][31]}}, vin_q[4]};
        3'd5: mul_a = {{(TW-32){vin_q[5][31]}}, vin_q[5]};
        default: mul_a = '0;
      endcase
    end else begin
      case (cnt_q)
        3'd0: begin
          mul_a = t_q[ri];
          mul_b = c_q;
        end
        3'd1: begin
          mul_a = t_q[rj];
          mul_b = -sn;
        end
        3'd2: begin
          mul_a = t_q[ri];
          mul_b = sn;
        end
        3'd3: begin
          mul_a = t_q[rj];
          mul_b = c_q;
        end
        default: begin
          mul_a = '0;
          mul_b = '0;
        end
      endcase
    end
  end

  assign mul_p = mul_a * mul_b;

  // (a*b + c*d + half) floored by 2^30
  assign mix_sum = acc_q + {prod_q[PW-1], prod_q} + (PW+1)'(1 << 29);
  assign mix_res = TW'(mix_sum >>> 30);
  // rate*dt or v*dt rounded back to the operand's q format
  assign rnd16   = (prod_q + PW'(1 << 15)) >>> 16;

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    axis_d  = axis_q;
    case (state_q)
      S_IDLE: begin
        cnt_d  = '0;
        axis_d = '0;
        if (accept && in_i.payload.action == ACT_PREDICT) begin
          if (in_i.payload.step_time[31]) state_d = S_FIN;
          else state_d = S_MUL;
        end
      end
      S_MUL: begin
        cnt_d = cnt_q + 3'd1;
        if (cnt_q == 3'd6) begin
          cnt_d   = '0;
          state_d = S_TRIG;
        end
      end
      S_TRIG: state_d = S_WAIT;
      S_WAIT: begin
        cnt_d = '0;
        if (cordic_done) state_d = S_ROT;
      end
      S_ROT: begin
        cnt_d = cnt_q + 3'd1;
        if (cnt_q == 3'd4) begin
          cnt_d = '0;
          if (axis_q == 2'd2) begin
            state_d = S_FIN;
          end else begin
            axis_d  = axis_q + 2'd1;
            state_d = S_TRIG;
          end
        end
      end
      S_FIN: begin
        if (!out_valid_q || out_o.ready) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      axis_q      <= '0;
      out_valid_q <= 1'b0;
      for (int k = 0; k < 3; k++) begin
        pose_pos_q[k] <= '0;
        pose_ang_q[k] <= '0;
      end
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      axis_q  <= axis_d;
      if (accept && in_i.payload.action == ACT_LOAD) begin
        pose_pos_q[0] <= in_i.payload.vec_x;
        pose_pos_q[1] <= in_i.payload.vec_y;
        pose_pos_q[2] <= in_i.payload.vec_z;
        pose_ang_q[0] <= in_i.payload.ang_x;
        pose_ang_q[1] <= in_i.payload.ang_y;
        pose_ang_q[2] <= in_i.payload.ang_z;
      end
      if (state_q == S_FIN && (!out_valid_q || out_o.ready)) out_valid_q <= 1'b1;
      else if (out_o.ready) out_valid_q <= 1'b0;
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    prod_q <= mul_p;
    if (accept) begin
      vin_q[0] <= in_i.payload.ang_x;
      vin_q[1] <= in_i.payload.ang_y;
      vin_q[2] <= in_i.payload.ang_z;
      vin_q[3] <= in_i.payload.vec_x;
      vin_q[4] <= in_i.payload.vec_y;
      vin_q[5] <= in_i.payload.vec_z;
      dt_q     <= in_i.payload.step_time;
      // negative dt path: pose unchanged, zero translation
      for (int k = 0; k < 3; k++) begin
        ang_q[k] <= pose_ang_q[k];
        t_q[k]   <= '0;
      end
    end
    if (state_q == S_MUL && cnt_q != 3'd0) begin
      case (cnt_q)
        3'd1: ang_q[0] <= sat32(72'(pose_ang_q[0]) + 72'(rnd16));
        3'd2: ang_q[1] <= sat32(72'(pose_ang_q[1]) + 72'(rnd16));
        3'd3: ang_q[2] <= sat32(72'(pose_ang_q[2]) + 72'(rnd16));
        3'd4: t_q[0] <= TW'(sat32(72'(rnd16)));
        3'd5: t_q[1] <= TW'(sat32(72'(rnd16)));
        3'd6: t_q[2] <= TW'(sat32(72'(rnd16)));
        default: ;
      endcase
    end
    if (state_q == S_WAIT && cordic_done) begin
      s_q <= cordic_sin;
      c_q <= cordic_cos;
    end
    if (state_q == S_ROT) begin
      case (cnt_q)
        3'd1: acc_q <= {prod_q[PW-1], prod_q};
        3'd2: t_q[ri] <= mix_res;
        3'd3: acc_q <= {prod_q[PW-1], prod_q};
        3'd4: t_q[rj] <= mix_res;
        default: ;
      endcase
    end
    if (state_q == S_FIN && (!out_valid_q || out_o.ready)) begin
      out_q.next_x     <= sat32(72'(pose_pos_q[0]) + 72'(t_q[0]));
      out_q.next_y     <= sat32(72'(pose_pos_q[1]) + 72'(t_q[1]));
      out_q.next_z     <= sat32(72'(pose_pos_q[2]) + 72'(t_q[2]));
      out_q.next_roll  <= ang_q[0];
      out_q.next_pitch <= ang_q[1];
      out_q.next_yaw   <= ang_q[2];
    end
  end

  assign out_o.valid   = out_valid_q;
  assign out_o.payload = out_q;

  `PDR_ASSERT_NOW(a_busy_not_ready, state_q != S_IDLE, !in_i.ready)
  `PDR_ASSERT_NOW(a_done_only_waiting, cordic_done, state_q == S_WAIT)
  `PDR_ASSERT_NEXT(a_neg_dt_short,
    accept && in_i.payload.action == ACT_PREDICT && in_i.payload.step_time[31],
    state_q == S_FIN)
  `PDR_ASSERT_NEXT(a_load_stays_idle,
    accept && in_i.payload.action == ACT_LOAD, state_q == S_IDLE)

endmodule
